// File: rtl/kced_pkg.sv
package kced_pkg;

  // group store and field widths
  localparam int unsigned GROUP_COUNT = 4;
  localparam int unsigned GRP_W       = 2;
  localparam int unsigned BITS_W      = 32;
  localparam int unsigned BIT_IDX_W   = 5;
  localparam int unsigned KEY_W       = 7;
  localparam int unsigned HALF_W      = 16;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // pad size codes
  typedef enum logic [1:0] {
    PAD_24  = 2'd0,
    PAD_60  = 2'd1,
    PAD_80  = 2'd2,
    PAD_128 = 2'd3
  } pad_size_e;

  // register indexes
  typedef enum logic {
    REG_STICK_MODE = 1'b0,
    REG_PAD_SIZE   = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [GRP_W-1:0]  group_index;
    logic [BITS_W-1:0] group_bits;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             pressed;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic      stick_mode;
    pad_size_e pad_size;
  } cfg_t;

  // one classified item waiting for the back end
  typedef struct packed {
    logic [BITS_W-1:0] changes;
    logic [BITS_W-1:0] bits;
    logic [GRP_W-1:0]  grp;
    logic              stick;
  } job_t;

  // number of groups the current pad uses
  function automatic logic [2:0] active_groups(cfg_t cfg);
    logic [2:0] n;
    if (cfg.stick_mode) begin
      n = 3'd1;
    end else begin
      case (cfg.pad_size)
        PAD_24:         n = 3'd1;
        PAD_60, PAD_80: n = 3'd3;
        default:        n = 3'd4;
      endcase
    end
    return n;
  endfunction

  // key number of a bit: transposed in stick layout, else bit plus 32 per group
  function automatic logic [KEY_W-1:0] key_number(logic stick, logic [GRP_W-1:0] grp,
                                                  logic [BIT_IDX_W-1:0] idx);
    logic [KEY_W-1:0] k;
    if (stick) begin
      k = {2'b00, idx[2:0], idx[4:3]};
    end else begin
      k = {grp, idx};
    end
    return k;
  endfunction

endpackage

// File: rtl/kced_front.sv
module kced_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  kced_pkg::in_item_t in_item_i,
  input  kced_pkg::cfg_t  cfg_i,
  output kced_pkg::job_t  job_o,
  output logic            job_push_o,
  input  logic            job_full_i
);

  logic [kced_pkg::BITS_W-1:0] prev_q [kced_pkg::GROUP_COUNT];
  logic [2:0]                  groups;
  logic                        accept;
  logic                        in_range;
  logic [kced_pkg::BITS_W-1:0] bits_masked;
  logic [kced_pkg::BITS_W-1:0] changes;

  // item handshake follows the job queue
  assign full_o = job_full_i;
  assign accept = push_i && !job_full_i;

  // classify: range check, half group mask, change mask
  always_comb begin
    groups   = kced_pkg::active_groups(cfg_i);
    in_range = ({1'b0, in_item_i.group_index} < groups) &&
               ({1'b0, in_item_i.group_index} < 3'(kced_pkg::GROUP_COUNT));
    if (groups == 3'd3 && in_item_i.group_index == 2'd2) begin
      bits_masked = {{kced_pkg::HALF_W{1'b0}}, in_item_i.group_bits[kced_pkg::HALF_W-1:0]};
    end else begin
      bits_masked = in_item_i.group_bits;
    end
    changes = bits_masked ^ prev_q[in_item_i.group_index];
  end

  assign job_push_o    = accept && in_range && (changes != '0);
  assign job_o.changes = changes;
  assign job_o.bits    = bits_masked;
  assign job_o.grp     = in_item_i.group_index;
  assign job_o.stick   = cfg_i.stick_mode;

  // stored previous bits per group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < kced_pkg::GROUP_COUNT; g++) begin
        prev_q[g] <= '0;
      end
    end else if (job_push_o) begin
      prev_q[in_item_i.group_index] <= bits_masked;
    end
  end

endmodule

// File: rtl/kced_queue.sv
module kced_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  kced_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output kced_pkg::job_t data_o
);

  kced_pkg::job_t                mem_q [kced_pkg::QUEUE_DEPTH];
  logic [kced_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [kced_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [kced_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                          do_push, do_pop;

  assign full_o  = (count_q == kced_pkg::QCNT_W'(kced_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == kced_pkg::QPTR_W'(kced_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == kced_pkg::QPTR_W'(kced_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/kced_back.sv
module kced_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kced_pkg::job_t     job_i,
  input  logic               job_empty_i,
  output logic               job_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output kced_pkg::out_item_t out_item_o
);

  logic                           active_q, active_d;
  logic [kced_pkg::BITS_W-1:0]    chg_q, chg_d;
  logic [kced_pkg::BITS_W-1:0]    bits_q, bits_d;
  logic [kced_pkg::BIT_IDX_W-1:0] idx_q, idx_d;
  logic [kced_pkg::GRP_W-1:0]     grp_q, grp_d;
  logic                           stick_q, stick_d;
  logic                           out_vld_q, out_vld_d;
  kced_pkg::out_item_t            out_q, out_d;
  logic                           out_free, emit, step;
  logic [kced_pkg::BITS_W-1:0]    chg_next;

  assign out_free  = !out_vld_q || pop_i;
  assign job_pop_o = !active_q && !job_empty_i;
  assign emit      = active_q && chg_q[0] && out_free;
  assign step      = active_q && (!chg_q[0] || out_free);
  assign chg_next  = chg_q >> 1;

  assign empty_o    = !out_vld_q;
  assign out_item_o = out_q;

  // scan the change mask one bit position per cycle, holding on a changed bit until the output register is free
  always_comb begin
    active_d = active_q;
    chg_d    = chg_q;
    bits_d   = bits_q;
    idx_d    = idx_q;
    grp_d    = grp_q;
    stick_d  = stick_q;
    if (job_pop_o) begin
      active_d = 1'b1;
      chg_d    = job_i.changes;
      bits_d   = job_i.bits;
      idx_d    = '0;
      grp_d    = job_i.grp;
      stick_d  = job_i.stick;
    end else if (step) begin
      active_d = (chg_next != '0);
      chg_d    = chg_next;
      bits_d   = bits_q >> 1;
      idx_d    = idx_q + 1'b1;
    end
  end

  // output register toward the result side
  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (emit) begin
      out_vld_d         = 1'b1;
      out_d.key_index   = kced_pkg::key_number(stick_q, grp_q, idx_q);
      out_d.pressed     = bits_q[0];
      out_d.last        = (chg_next == '0);
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chg_q   <= chg_d;
    bits_q  <= bits_d;
    idx_q   <= idx_d;
    grp_q   <= grp_d;
    stick_q <= stick_d;
    out_q   <= out_d;
  end

endmodule

// File: rtl/key_change_event_detector_top.sv
// path: on an idle block the first event of an item passes the job queue, the back-end scan
//   registers and the output register; each unchanged bit below the lowest changed bit adds a scan step
// throughput: the back end scans the change mask one bit per cycle while the output register is
//   free, loading an item and then stepping up to its highest changed bit, so a low highest
//   changed bit ends the scan early; a two-entry job queue lets the front accept meanwhile
// reset: asynchronous, active low; clears stored group bits, registers, queue and output
module key_change_event_detector_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kced_pkg::ADDR_W-1:0]   paddr,
  input  logic [kced_pkg::DATA_W-1:0]   pwdata,
  output logic [kced_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  kced_pkg::in_item_t            in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output kced_pkg::out_item_t           out_item_o
);

  kced_pkg::cfg_t       cfg_q, cfg_d;
  kced_pkg::reg_index_e reg_idx;
  logic                 cfg_wr;
  kced_pkg::job_t       fr_job, q_job;
  logic                 job_push, job_full, job_pop, job_empty;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = kced_pkg::reg_index_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        kced_pkg::REG_STICK_MODE: cfg_d.stick_mode = pwdata[0];
        kced_pkg::REG_PAD_SIZE:   cfg_d.pad_size   = kced_pkg::pad_size_e'(pwdata[1:0]);
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kced_pkg::REG_STICK_MODE: prdata = {{(kced_pkg::DATA_W-1){1'b0}}, cfg_q.stick_mode};
      kced_pkg::REG_PAD_SIZE:   prdata = {{(kced_pkg::DATA_W-2){1'b0}}, cfg_q.pad_size};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stick_mode <= 1'b0;
      cfg_q.pad_size   <= kced_pkg::PAD_24;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: accept and classify items
  kced_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .job_o      (fr_job),
    .job_push_o (job_push),
    .job_full_i (job_full)
  );

  // job queue
  kced_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (fr_job),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (q_job)
  );

  // back: emit one event per changed bit
  kced_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/kced_checker.sv
module kced_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [kced_pkg::ADDR_W-1:0] paddr,
  input logic [kced_pkg::DATA_W-1:0] pwdata,
  input logic [kced_pkg::DATA_W-1:0] prdata,
  input logic                        pready,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input kced_pkg::out_item_t         out_item_o
);

  // reset leaves both queues drained
  a_reset_drained: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("queues not drained in reset");

  // a waiting item is not withdrawn
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting item withdrawn");

  // a waiting item keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(out_item_o))
    else $error("waiting item changed");

  // stick mode register reads back what was written just before
  a_stick_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(psel && penable && pwrite && pready &&
           (paddr == {kced_pkg::REG_STICK_MODE, 2'b00})) &&
     psel && !pwrite && (paddr == {kced_pkg::REG_STICK_MODE, 2'b00}))
    |-> (prdata[0] == $past(pwdata[0])))
    else $error("stick mode readback mismatch");

endmodule

bind key_change_event_detector_top kced_checker u_kced_checker (.*);

// File: test/tb_key_change_event_detector_top.sv
`timescale 1ns / 1ps

module tb_key_change_event_detector_top;

  localparam int unsigned CYCLE_LIMIT   = 100000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned IDLE_PCT      = 21;
  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS   = 18;
  localparam int unsigned TABLE_ROWS    = 27;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {
    BY_MODEL,
    TYPED_NONE,
    TYPED_ONE
  } row_check_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic                        stick;
    kced_pkg::pad_size_e         pad;
    logic [kced_pkg::GRP_W-1:0]  grp;
    logic [kced_pkg::BITS_W-1:0] bits;
    row_check_e                  check;
    logic [kced_pkg::KEY_W-1:0]  key;
    logic                        pressed;
  } row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [kced_pkg::ADDR_W-1:0] paddr;
  logic [kced_pkg::DATA_W-1:0] pwdata;
  logic [kced_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  logic                        push;
  logic                        full;
  kced_pkg::in_item_t          in_item_i;
  logic                        empty;
  logic                        pop;
  kced_pkg::out_item_t         out_item_o;

  key_change_event_detector_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted block state
  logic [kced_pkg::BITS_W-1:0] stored_bits [kced_pkg::GROUP_COUNT];
  logic                        cfg_stick;
  kced_pkg::pad_size_e         cfg_pad;

  kced_pkg::out_item_t expected_events [$];
  kced_pkg::out_item_t new_events [$];
  int unsigned mismatches     = 0;
  int unsigned items_accepted = 0;
  int unsigned events_checked = 0;
  int unsigned settings_used  = 0;
  int unsigned cycles         = 0;
  logic        gaps_on;
  logic        hold_request;

  row_t                stim_table [TABLE_ROWS];
  logic                phase_stick [RAND_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
  kced_pkg::pad_size_e phase_pad [RAND_PHASES]   = '{
    kced_pkg::PAD_128, kced_pkg::PAD_24, kced_pkg::PAD_60,
    kced_pkg::PAD_80, kced_pkg::PAD_24, kced_pkg::PAD_60
  };

  function automatic int unsigned groups_in_use();
    if (cfg_stick) begin
      return 1;
    end
    case (cfg_pad)
      kced_pkg::PAD_24:                   return 1;
      kced_pkg::PAD_60, kced_pkg::PAD_80: return 3;
      default:                            return 4;
    endcase
  endfunction

  // key events of one group word, stored bits updated
  function automatic void scan_group(kced_pkg::in_item_t it);
    int unsigned                 grp;
    int unsigned                 ngrp;
    int unsigned                 key;
    logic [kced_pkg::BITS_W-1:0] bits;
    logic [kced_pkg::BITS_W-1:0] changes;
    kced_pkg::out_item_t         ev;
    new_events.delete();
    grp  = it.group_index;
    bits = it.group_bits;
    ngrp = groups_in_use();
    if (grp >= ngrp) begin
      return;
    end
    // three-group pads keep only the low half of group 2
    if (ngrp == 3 && grp == 2) begin
      bits[31:16] = '0;
    end
    changes = bits ^ stored_bits[grp];
    for (int i = 0; i < kced_pkg::BITS_W; i++) begin
      if (changes[i]) begin
        key = cfg_stick ? (i / 8 + 4 * (i % 8)) : (i + 32 * grp);
        ev.key_index = kced_pkg::KEY_W'(key);
        ev.pressed   = bits[i];
        ev.last      = (i == kced_pkg::BITS_W - 1) || ((changes >> (i + 1)) == '0);
        new_events.push_back(ev);
      end
    end
    stored_bits[grp] = bits;
  endfunction

  // random group word, mostly small changes against the stored bits
  function automatic kced_pkg::in_item_t pick_group_item();
    kced_pkg::in_item_t          it;
    int unsigned                 ngrp;
    int unsigned                 roll;
    int unsigned                 flips;
    logic [kced_pkg::BITS_W-1:0] w;
    ngrp           = groups_in_use();
    roll           = $urandom_range(0, 99);
    it.group_index = kced_pkg::GRP_W'($urandom_range(0, ngrp - 1));
    w              = stored_bits[it.group_index];
    if (roll < 8 && ngrp < kced_pkg::GROUP_COUNT) begin
      it.group_index = kced_pkg::GRP_W'($urandom_range(ngrp, kced_pkg::GROUP_COUNT - 1));
      w              = $urandom();
    end else if (roll < 18) begin
      // same bits again, noise in the dropped half where there is one
      if (ngrp == 3 && it.group_index == 2) begin
        w[31:16] = 16'($urandom_range(0, 16'hFFFF));
      end
    end else if (roll < 34) begin
      w = $urandom();
    end else if (roll < 40) begin
      w = roll[0] ? '1 : '0;
    end else begin
      flips = $urandom_range(1, 4);
      repeat (flips) w ^= 32'd1 << $urandom_range(0, 31);
    end
    it.group_bits = w;
    return it;
  endfunction

  function automatic row_t item_row(logic [kced_pkg::GRP_W-1:0] g,
                                    logic [kced_pkg::BITS_W-1:0] b,
                                    row_check_e c, logic [kced_pkg::KEY_W-1:0] k = '0,
                                    logic p = 1'b0);
    row_t r;
    r         = '0;
    r.kind    = ROW_ITEM;
    r.pad     = kced_pkg::PAD_24;
    r.grp     = g;
    r.bits    = b;
    r.check   = c;
    r.key     = k;
    r.pressed = p;
    return r;
  endfunction

  function automatic row_t cfg_row(logic s, kced_pkg::pad_size_e p);
    row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.stick = s;
    r.pad   = p;
    r.check = BY_MODEL;
    return r;
  endfunction

  // offer one item until taken, then predict it
  task automatic offer_item(input kced_pkg::in_item_t it, input logic use_model);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push      <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_accepted++;
    scan_group(it);
    if (use_model) begin
      foreach (new_events[k]) expected_events.push_back(new_events[k]);
    end
  endtask

  task automatic wait_for_results(input int unsigned settle);
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // register write then read back, select left high for a following transfer
  task automatic write_reg(input kced_pkg::reg_index_e idx,
                           input logic [kced_pkg::DATA_W-1:0] value);
    logic [kced_pkg::DATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    if (readback !== value) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, idx, value, readback);
      mismatches++;
    end
  endtask

  task automatic apply_setting(input logic stick, input kced_pkg::pad_size_e pad);
    wait_for_results(SETTLE_CYCLES);
    write_reg(kced_pkg::REG_STICK_MODE, kced_pkg::DATA_W'(stick));
    write_reg(kced_pkg::REG_PAD_SIZE, kced_pkg::DATA_W'(pad));
    psel      <= 1'b0;
    penable   <= 1'b0;
    cfg_stick = stick;
    cfg_pad   = pad;
    settings_used++;
  endtask

  // result side: random pop while gaps are on, else pop held high; long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    pop        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!gaps_on) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // result check against the oldest expected event, plus run limit
  always @(posedge clk_i) begin
    kced_pkg::out_item_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d events outstanding", $time, expected_events.size());
      $display("FAIL key_change_event_detector_top");
      $finish;
    end else if (rst_ni && !empty && pop) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event expected none actual key %0d pressed %0b last %0b",
                 $time, out_item_o.key_index, out_item_o.pressed, out_item_o.last);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        events_checked++;
        if (out_item_o.key_index !== want.key_index || out_item_o.pressed !== want.pressed ||
            out_item_o.last !== want.last) begin
          $display(
            "%0t: expected key %0d pressed %0b last %0b, actual key %0d pressed %0b last %0b",
            $time, want.key_index, want.pressed, want.last,
            out_item_o.key_index, out_item_o.pressed, out_item_o.last);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    kced_pkg::in_item_t  it;
    row_t                row;
    kced_pkg::out_item_t typed_ev;
    rst_ni       = 1'b0;
    push         = 1'b0;
    in_item_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    gaps_on      = 1'b1;
    hold_request = 1'b0;
    cfg_stick    = 1'b0;
    cfg_pad      = kced_pkg::PAD_24;
    foreach (stored_bits[g]) stored_bits[g] = '0;

    stim_table = '{
      // 24-key pad after reset
      item_row(2'd0, 32'h0000_0001, TYPED_ONE, 7'd0, 1'b1),
      item_row(2'd0, 32'h0000_0001, TYPED_NONE),
      item_row(2'd0, 32'h0000_0000, TYPED_ONE, 7'd0, 1'b0),
      item_row(2'd1, 32'hFFFF_FFFF, TYPED_NONE),
      item_row(2'd0, 32'hFFFF_FFFF, BY_MODEL),
      item_row(2'd0, 32'h8000_0000, BY_MODEL),
      item_row(2'd3, 32'h1234_5678, TYPED_NONE),
      // 128 keys, all groups
      cfg_row(1'b0, kced_pkg::PAD_128),
      item_row(2'd3, 32'h8000_0000, TYPED_ONE, 7'd127, 1'b1),
      item_row(2'd3, 32'hFFFF_FFFF, BY_MODEL),
      item_row(2'd1, 32'hAAAA_AAAA, BY_MODEL),
      item_row(2'd2, 32'h5555_5555, BY_MODEL),
      item_row(2'd0, 32'h0000_0000, TYPED_ONE, 7'd31, 1'b0),
      // three groups, group 2 cut to its low half
      cfg_row(1'b0, kced_pkg::PAD_60),
      item_row(2'd2, 32'hFFFF_0000, BY_MODEL),
      item_row(2'd2, 32'hFFFF_0000, TYPED_NONE),
      item_row(2'd3, 32'hFFFF_FFFF, TYPED_NONE),
      cfg_row(1'b0, kced_pkg::PAD_80),
      item_row(2'd2, 32'hFFFF_FFFF, BY_MODEL),
      item_row(2'd1, 32'h0000_0000, BY_MODEL),
      // stick layout overrides the pad size
      cfg_row(1'b1, kced_pkg::PAD_128),
      item_row(2'd0, 32'h0000_0002, TYPED_ONE, 7'd4, 1'b1),
      item_row(2'd0, 32'hFFFF_FFFF, BY_MODEL),
      item_row(2'd1, 32'h0000_0001, TYPED_NONE),
      item_row(2'd0, 32'h8000_0000, BY_MODEL),
      // stored bits survive the mode change
      cfg_row(1'b0, kced_pkg::PAD_24),
      item_row(2'd0, 32'h0000_0000, TYPED_ONE, 7'd31, 1'b0)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < TABLE_ROWS; r++) begin
      row = stim_table[r];
      if (row.kind == ROW_CFG) begin
        apply_setting(row.stick, row.pad);
      end else begin
        it.group_index = row.grp;
        it.group_bits  = row.bits;
        offer_item(it, row.check == BY_MODEL);
        if (row.check == TYPED_ONE) begin
          typed_ev.key_index = row.key;
          typed_ev.pressed   = row.pressed;
          typed_ev.last      = 1'b1;
          expected_events.push_back(typed_ev);
        end
      end
    end

    // random phases, one setting each
    for (int p = 0; p < RAND_PHASES; p++) begin
      apply_setting(phase_stick[p], phase_pad[p]);
      gaps_on = (p != 0);
      if (p == 2) begin
        hold_request = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) begin
          wait_for_results(0);
        end
        offer_item(pick_group_item(), 1'b1);
      end
    end

    wait_for_results(SETTLE_CYCLES);
    if (expected_events.size() != 0) begin
      $display("%0t: expected %0d more events actual none", $time, expected_events.size());
      mismatches++;
    end

    $display("covered %0d items under %0d register settings, %0d key events checked",
             items_accepted, settings_used, events_checked);
    $display("incl. ignored and unchanged groups, half group 2, stick layout, output hold-off");
    if (mismatches == 0) begin
      $display("PASS key_change_event_detector_top");
    end else begin
      $display("FAIL key_change_event_detector_top");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/kced_pkg.sv
rtl/kced_front.sv
rtl/kced_queue.sv
rtl/kced_back.sv
rtl/key_change_event_detector_top.sv
rtl/kced_checker.sv
test/tb_key_change_event_detector_top.sv
